@@ hw/rtl/stsum_pkg.sv @@
package stsum_pkg;

    localparam int SUM_BITS   = 42;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 10;
    localparam int STATUS_W   = 2;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_BUILT = 2'd2;

    typedef struct packed {
        logic                      req_type;
        logic signed [VALUE_W-1:0] element_value;
        logic                      last_element;
        logic [INDEX_W-1:0]        left_index;
        logic [INDEX_W-1:0]        right_index;
    } stsum_req_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] range_sum;
        logic [STATUS_W-1:0]        status;
    } stsum_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_BFLUSH,
        ST_QUERY,
        ST_QSUM
    } stsum_state_t;

endpackage

@@ hw/rtl/sparse_table_range_sum.sv @@
// Sparse-table range-sum engine.
// Request channel: a transfer happens at a rising edge with start high and busy
// low. A load transfer (req_type 0) appends element_value to the array without
// raising busy, so loads can stream back to back; loads past MAX_ELEMENTS are
// dropped. A load with last_element set raises busy while the table is built
// level by level from one memory: level j, for every j >= 1 with 2^j <= count
// and j < LEVELS, is built over entries 0 to count - 2^j and then flushed. The
// build is bound by the single write port. A query transfer (req_type 1) walks
// the levels from the top down, one memory read per level, then sums in ST_QSUM;
// result_valid pulses for one cycle as busy drops, so the next request can be
// taken while result_valid is high. Errors (no table yet, right index past the
// loaded length) and an empty range report a zero sum the same way. The
// receiver cannot stall: each result is qualified by result_valid for exactly
// one cycle and stays on the result port until the next one. The first load
// after a build starts a new array and queries report not built until its last
// element arrives. Reset empties the array and marks the table not built; table
// memory is kept, since only entries of the latest loads and build are read.
module sparse_table_range_sum #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11,
    parameter int VALUE_BITS   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  stsum_pkg::stsum_req_t request,
    output logic               busy,
    output logic               result_valid,
    output stsum_pkg::stsum_res_t result
);

    import stsum_pkg::*;

    localparam int AW     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LW     = $clog2(LEVELS);
    localparam int CW     = $clog2(MAX_ELEMENTS + 1);
    localparam int LENW   = ((LEVELS > CW) ? LEVELS : CW) + 1;
    localparam int PW     = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam int RW     = INDEX_W + 1;
    localparam int CMPW   = (LENW > PW) ? LENW : PW;
    localparam int MEM_AW = LW + AW;

    localparam logic [LW-1:0] TOP_LEVEL = LW'(LEVELS - 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ELEMENTS);

    stsum_state_t         state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 built_reg, built_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [AW-1:0]        wr_idx_reg, wr_idx_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [RW-1:0]        remain_reg, remain_next;
    logic [SUM_BITS-1:0]  acc_reg, acc_next;
    logic                 rdq_reg, rdq_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 result_valid_reg, result_valid_next;
    stsum_res_t           result_reg, result_next;

    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_waddr;
    logic [SUM_BITS-1:0]  mem_wdata;
    logic [MEM_AW-1:0]    rd_addr_a, rd_addr_b;
    logic [SUM_BITS-1:0]  rd_data_a, rd_data_b;

    logic                 accept;
    logic signed [VALUE_BITS-1:0] load_val;
    logic [SUM_BITS-1:0]  load_ext;
    logic [CW-1:0]        base_cnt;
    logic                 room;
    logic [CW-1:0]        cnt_after;
    logic [LW-1:0]        prev_lvl;
    logic [LENW-1:0]      lvl_len, half_len, last_start;
    logic                 idx_is_last;
    logic [AW-1:0]        idx_plus_half;
    logic [LW:0]          nlvl_w;
    logic                 more_levels;
    logic                 take;
    logic [STATUS_W-1:0]  q_status;
    logic [RW-1:0]        q_remain;

    stsum_mem #(
        .ADDR_BITS(MEM_AW),
        .DATA_BITS(SUM_BITS)
    ) u_mem (
        .clk      (clk),
        .wr_en    (mem_we),
        .wr_addr  (mem_waddr),
        .wr_data  (mem_wdata),
        .rd_addr_a(rd_addr_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_a(rd_data_a),
        .rd_data_b(rd_data_b)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // element taken as raw bits, sign from bit VALUE_BITS-1
    assign load_val  = VALUE_BITS'($unsigned(request.element_value));
    assign load_ext  = SUM_BITS'(load_val);
    assign base_cnt  = built_reg ? '0 : count_reg;
    assign room      = (base_cnt < MAX_COUNT);
    assign cnt_after = room ? CW'(base_cnt + CW'(1)) : base_cnt;

    // build walk helpers
    assign prev_lvl      = lvl_reg - LW'(1);
    assign lvl_len       = LENW'(1) << lvl_reg;
    assign half_len      = LENW'(1) << prev_lvl;
    assign last_start    = LENW'(count_reg) - lvl_len;
    assign idx_is_last   = (LENW'(idx_reg) == last_start);
    assign idx_plus_half = AW'(LENW'(idx_reg) + half_len);
    assign nlvl_w        = (LW + 1)'(lvl_reg) + (LW + 1)'(1);
    assign more_levels   = (nlvl_w < (LW + 1)'(LEVELS))
                        && ((LENW'(1) << nlvl_w) <= LENW'(count_reg));

    // query walk: take the block at this level if it still fits
    assign take = (CMPW'(lvl_len) <= CMPW'(remain_reg));

    always_comb
    begin
        priority if (!built_reg)
        begin
            q_status = STATUS_NOT_BUILT;
        end
        else if (CMPW'(request.right_index) >= CMPW'(count_reg))
        begin
            q_status = STATUS_RANGE;
        end
        else
        begin
            q_status = STATUS_OK;
        end
        if (q_status == STATUS_OK && request.left_index <= request.right_index)
        begin
            q_remain = RW'(request.right_index) - RW'(request.left_index) + RW'(1);
        end
        else
        begin
            q_remain = '0;
        end
    end

    // read ports: A serves the query and the lower half of a build pair
    always_comb
    begin
        if (state_reg == ST_BUILD)
        begin
            rd_addr_a = {prev_lvl, idx_reg};
        end
        else
        begin
            rd_addr_a = {lvl_reg, pos_reg[AW-1:0]};
        end
        rd_addr_b = {prev_lvl, idx_plus_half};
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        built_next        = built_reg;
        lvl_next          = lvl_reg;
        idx_next          = idx_reg;
        wr_pend_next      = 1'b0;
        wr_idx_next       = wr_idx_reg;
        pos_next          = pos_reg;
        remain_next       = remain_reg;
        acc_next          = acc_reg;
        rdq_next          = 1'b0;
        status_next       = status_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        mem_we            = 1'b0;
        mem_waddr         = {lvl_reg, wr_idx_reg};
        mem_wdata         = rd_data_a + rd_data_b;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.req_type == REQ_LOAD)
                    begin
                        if (room)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = {LW'(0), base_cnt[AW-1:0]};
                            mem_wdata = load_ext;
                        end
                        count_next = cnt_after;
                        built_next = 1'b0;
                        if (request.last_element)
                        begin
                            if (cnt_after >= CW'(2))
                            begin
                                lvl_next   = LW'(1);
                                idx_next   = '0;
                                state_next = ST_BUILD;
                            end
                            else
                            begin
                                built_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        status_next = q_status;
                        remain_next = q_remain;
                        pos_next    = PW'(request.left_index);
                        lvl_next    = TOP_LEVEL;
                        acc_next    = '0;
                        state_next  = ST_QUERY;
                    end
                end
            end

            ST_BUILD:
            begin
                wr_pend_next = 1'b1;
                wr_idx_next  = idx_reg;
                if (idx_is_last)
                begin
                    idx_next   = '0;
                    state_next = ST_BFLUSH;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
                if (wr_pend_reg)
                begin
                    mem_we = 1'b1;
                end
            end

            ST_BFLUSH:
            begin
                // last write of the level lands before the next level reads it
                mem_we = wr_pend_reg;
                if (more_levels)
                begin
                    lvl_next   = nlvl_w[LW-1:0];
                    state_next = ST_BUILD;
                end
                else
                begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_QUERY:
            begin
                if (rdq_reg)
                begin
                    acc_next = acc_reg + rd_data_a;
                end
                rdq_next = take;
                if (take)
                begin
                    pos_next    = pos_reg + PW'(lvl_len);
                    remain_next = remain_reg - RW'(lvl_len);
                end
                if (lvl_reg == '0)
                begin
                    state_next = ST_QSUM;
                end
                else
                begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end

            ST_QSUM:
            begin
                result_next.range_sum = rdq_reg ? acc_reg + rd_data_a : acc_reg;
                result_next.status    = status_reg;
                result_valid_next     = 1'b1;
                state_next            = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            built_reg        <= 1'b0;
            wr_pend_reg      <= 1'b0;
            rdq_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            built_reg        <= built_next;
            wr_pend_reg      <= wr_pend_next;
            rdq_reg          <= rdq_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg    <= lvl_next;
        idx_reg    <= idx_next;
        wr_idx_reg <= wr_idx_next;
        pos_reg    <= pos_next;
        remain_reg <= remain_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    // a result only ever follows the final accumulate step
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_QSUM))
        else $error("result strobe without a finished query walk");

    // every accepted query must be answered by a result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.req_type == REQ_QUERY |-> ##(LEVELS + 2) result_valid)
        else $error("query result missing at its fixed latency");

    // any error status must come with a zero sum
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != STATUS_OK |-> result.range_sum == '0)
        else $error("nonzero sum on an error result");

    // a pending build write only exists inside the build walk
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> state_reg == ST_BUILD || state_reg == ST_BFLUSH)
        else $error("build write pending outside the build");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("element count above capacity");

endmodule

@@ hw/rtl/stsum_mem.sv @@
module stsum_mem #(
    parameter int ADDR_BITS = 14,
    parameter int DATA_BITS = 42
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr_a,
    input  logic [ADDR_BITS-1:0] rd_addr_b,
    output logic [DATA_BITS-1:0] rd_data_a,
    output logic [DATA_BITS-1:0] rd_data_b
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered reads, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
